// ===== rtl/core/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IDX_WIDTH   = 10;
  // Range bounds need one extra bit each way: hi can drop to -1, lo can reach 2**IDX_WIDTH.
  localparam int PTR_WIDTH   = IDX_WIDTH + 2;
  localparam int STEP_WIDTH  = 3;
  localparam int COND_WIDTH  = 3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Microprogram step addresses
  localparam logic [STEP_WIDTH-1:0] S_IDLE  = 3'd0;
  localparam logic [STEP_WIDTH-1:0] S_SPLIT = 3'd1;
  localparam logic [STEP_WIDTH-1:0] S_ADDR  = 3'd2;
  localparam logic [STEP_WIDTH-1:0] S_READ  = 3'd3;
  localparam logic [STEP_WIDTH-1:0] S_CMP   = 3'd4;
  localparam logic [STEP_WIDTH-1:0] S_DONE  = 3'd5;

  // Branch conditions
  localparam logic [COND_WIDTH-1:0] COND_ALWAYS   = 3'd0;
  localparam logic [COND_WIDTH-1:0] COND_START    = 3'd1;
  localparam logic [COND_WIDTH-1:0] COND_EMPTY    = 3'd2;
  localparam logic [COND_WIDTH-1:0] COND_HIT      = 3'd3;
  localparam logic [COND_WIDTH-1:0] COND_OUT_FREE = 3'd4;

  typedef struct packed {
    logic                          action;
    logic [IDX_WIDTH-1:0]          position;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic [IDX_WIDTH-1:0]          first_index;
    logic [IDX_WIDTH-1:0]          last_index;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_WIDTH-1:0] found_index;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic do_split;
    logic do_addr;
    logic do_read;
    logic do_cmp;
    logic do_done;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic empty;
    logic hit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [COND_WIDTH-1:0] cond;
    logic [STEP_WIDTH-1:0] go_true;
    logic [STEP_WIDTH-1:0] go_false;
    ctrl_t                 ctrl;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [STEP_WIDTH-1:0] step);
    uword_t w;
    w          = '0;
    w.cond     = COND_ALWAYS;
    w.go_true  = S_IDLE;
    w.go_false = S_IDLE;
    case (step)
      S_IDLE: begin
        w.cond      = COND_START;
        w.go_true   = S_SPLIT;
        w.go_false  = S_IDLE;
        w.ctrl.idle = 1'b1;
      end
      S_SPLIT: begin
        w.cond          = COND_EMPTY;
        w.go_true       = S_DONE;
        w.go_false      = S_ADDR;
        w.ctrl.do_split = 1'b1;
      end
      S_ADDR: begin
        w.go_true      = S_READ;
        w.ctrl.do_addr = 1'b1;
      end
      S_READ: begin
        w.go_true      = S_CMP;
        w.ctrl.do_read = 1'b1;
      end
      S_CMP: begin
        w.cond        = COND_HIT;
        w.go_true     = S_DONE;
        w.go_false    = S_SPLIT;
        w.ctrl.do_cmp = 1'b1;
      end
      S_DONE: begin
        w.cond         = COND_OUT_FREE;
        w.go_true      = S_IDLE;
        w.go_false     = S_DONE;
        w.ctrl.do_done = 1'b1;
      end
      default: begin
        w.go_true  = S_IDLE;
        w.go_false = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // floor(x / 3) for x < 2048, as x * 683 >> 11
  function automatic logic [IDX_WIDTH-1:0] div3(input logic [IDX_WIDTH:0] x);
    logic [2*IDX_WIDTH+1:0] p;
    p = (2*IDX_WIDTH+2)'(x) * (2*IDX_WIDTH+2)'(683);
    return p[2*IDX_WIDTH:IDX_WIDTH+1];
  endfunction

endpackage

// ===== rtl/core/tss_ram.sv =====
`timescale 1ns / 1ps

module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                             rdata_a,
  output logic [WIDTH-1:0]                             rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/tss_useq.sv =====
`timescale 1ns / 1ps

module tss_useq import tss_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_WIDTH-1:0] step;
  logic [STEP_WIDTH-1:0] step_next;
  uword_t                uw;
  logic                  cond_ok;

  always_comb begin
    uw = ucode(step);
    case (uw.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_START:    cond_ok = stat.start;
      COND_EMPTY:    cond_ok = stat.empty;
      COND_HIT:      cond_ok = stat.hit;
      COND_OUT_FREE: cond_ok = stat.out_free;
      default:       cond_ok = 1'b1;
    endcase
    step_next = cond_ok ? uw.go_true : uw.go_false;
    ctrl      = uw.ctrl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/tss_dpath.sv =====
`timescale 1ns / 1ps

module tss_dpath import tss_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  req_t  req,
  input  ctrl_t ctrl,
  output stat_t stat,
  input  logic  rsp_ready,
  output logic  rsp_valid,
  output rsp_t  rsp
);

  // Indexes stop at 2**IDX_WIDTH - 1, so deeper tables never use their upper part.
  localparam int MEM_DEPTH  = (TABLE_DEPTH < (1 << IDX_WIDTH)) ? TABLE_DEPTH : (1 << IDX_WIDTH);
  localparam int ADDR_WIDTH = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [IDX_WIDTH:0] MEM_LIMIT = (IDX_WIDTH + 1)'(MEM_DEPTH);

  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [PTR_WIDTH-1:0]   lo;
  logic signed [PTR_WIDTH-1:0]   hi;
  logic [IDX_WIDTH-1:0]          q1;
  logic [IDX_WIDTH-1:0]          q2;
  logic [IDX_WIDTH-1:0]          left;
  logic [IDX_WIDTH-1:0]          right;
  logic                          oob_l;
  logic                          oob_r;
  logic                          found;
  logic [IDX_WIDTH-1:0]          found_index;

  logic [IDX_WIDTH-1:0]          span;
  logic                          we;
  logic [VALUE_WIDTH-1:0]        rd_a;
  logic [VALUE_WIDTH-1:0]        rd_b;
  logic signed [VALUE_WIDTH-1:0] lval;
  logic signed [VALUE_WIDTH-1:0] rval;
  logic                          hit_l;
  logic                          hit_r;
  logic signed [PTR_WIDTH-1:0]   left_ext;
  logic signed [PTR_WIDTH-1:0]   right_ext;
  logic                          start;

  assign start = ctrl.idle && !rst && req_valid && (req.action == ACT_SEARCH);
  assign we    = ctrl.idle && !rst && req_valid && (req.action == ACT_WRITE)
                 && ({1'b0, req.position} < MEM_LIMIT);

  tss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (req.position[ADDR_WIDTH-1:0]),
    .wdata   (req.item_value),
    .re      (ctrl.do_read),
    .raddr_a (left[ADDR_WIDTH-1:0]),
    .raddr_b (right[ADDR_WIDTH-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign span      = IDX_WIDTH'(hi - lo);
  // entries past the table read as zero
  assign lval      = oob_l ? '0 : $signed(rd_a);
  assign rval      = oob_r ? '0 : $signed(rd_b);
  assign hit_l     = (lval == key);
  assign hit_r     = (rval == key);
  assign left_ext  = $signed({2'b00, left});
  assign right_ext = $signed({2'b00, right});

  assign stat.start    = start;
  assign stat.empty    = (lo > hi);
  assign stat.hit      = hit_l || hit_r;
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (start) begin
      key         <= req.item_value;
      lo          <= $signed({2'b00, req.first_index});
      hi          <= $signed({2'b00, req.last_index});
      found       <= 1'b0;
      found_index <= '0;
    end
    if (ctrl.do_split) begin
      q1 <= div3({1'b0, span});
      q2 <= div3({span, 1'b0});
    end
    if (ctrl.do_addr) begin
      left  <= lo[IDX_WIDTH-1:0] + q1;
      right <= lo[IDX_WIDTH-1:0] + q2;
    end
    if (ctrl.do_read) begin
      oob_l <= ({1'b0, left} >= MEM_LIMIT);
      oob_r <= ({1'b0, right} >= MEM_LIMIT);
    end
    if (ctrl.do_cmp) begin
      if (hit_l) begin
        found       <= 1'b1;
        found_index <= left;
      end else if (hit_r) begin
        found       <= 1'b1;
        found_index <= right;
      end else if (key < lval) begin
        hi <= left_ext - PTR_WIDTH'(1);
      end else if (key > rval) begin
        lo <= right_ext + PTR_WIDTH'(1);
      end else begin
        lo <= left_ext + PTR_WIDTH'(1);
        hi <= right_ext - PTR_WIDTH'(1);
      end
    end
    if (ctrl.do_done && stat.out_free) begin
      rsp.found       <= found;
      rsp.found_index <= found_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.do_done && stat.out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/ternary_search_sorted_table.sv =====
`timescale 1ns / 1ps
// Write transactions: taken one per cycle while idle, no response.
// Search transactions: each narrowing round steps through split, address, table read, compare;
//   the done step follows a hit at compare, or a split that finds the range empty on a miss;
//   rsp_valid rises when done loads the output; a full 1024-entry range takes at most 7 rounds.
// The next request is taken in the cycle after the response is loaded into the output register.
// Reset (rst, synchronous): sequencer idle, rsp_valid and req_ready low, table kept as is.
module ternary_search_sorted_table import tss_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // Control flows from the microcoded sequencer, status flows back from the datapath.
  ctrl_t ctrl;
  stat_t stat;

  tss_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Datapath: search bounds, split points, the two-read table memory and the response register.
  tss_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Requests are only taken while the sequencer sits in its idle step and reset is off.
  assign req_ready = ctrl.idle && !rst;

  // A search transaction starts the program, so the request side closes next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.action == ACT_SEARCH) |=> !req_ready)
    else $error("request side still open after a search transaction");

  // A write transaction leaves the sequencer idle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.action == ACT_WRITE) |=> req_ready)
    else $error("write transaction left the block busy");

  // A miss always reports index zero.
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> (rsp.found_index == '0))
    else $error("miss response with nonzero index");

  // A hit in the compare step is followed by the done step, never another split.
  a_hit_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.do_cmp && stat.hit |=> ctrl.do_done)
    else $error("hit did not end the search");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tss_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = ~VAL_MIN;
  localparam int RANDOM_ITEMS = 760;
  localparam int LONG_HOLD    = 300;   // receiver stall long enough to back up the request side
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either channel
  localparam int SETTLE       = 40;    // a bit more than one full-range search

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Local copy of the table, updated as write transactions are accepted.
  logic signed [VALUE_WIDTH-1:0] table_copy [TABLE_DEPTH];
  // Search answers still owed by the block, oldest first.
  rsp_t pending_answers[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;       // no random idling on either side
  bit  hold_request = 1'b0; // asks the receiver for one long stall

  typedef struct {
    req_t item;
    bit   typed;   // answer written in the row rather than predicted
    rsp_t answer;
  } dir_row_t;

  dir_row_t directed_rows[$];

  ternary_search_sorted_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Ternary narrowing over the local table copy. Split points at one third and
  // two thirds of the inclusive range; stop on a hit at either point, else keep
  // the left, right or middle part. An empty range answers not-found at 0.
  function automatic rsp_t search_table(input logic signed [VALUE_WIDTH-1:0] key,
                                        input int lo, input int hi);
    rsp_t res;
    int   span;
    int   left;
    int   right;
    res = '0;
    while (lo <= hi) begin
      span  = hi - lo;
      left  = lo + span / 3;
      right = lo + (2 * span) / 3;
      if (table_copy[left] == key) begin
        res.found       = 1'b1;
        res.found_index = IDX_WIDTH'(left);
        return res;
      end
      if (table_copy[right] == key) begin
        res.found       = 1'b1;
        res.found_index = IDX_WIDTH'(right);
        return res;
      end
      if (key < table_copy[left]) begin
        hi = left - 1;
      end else if (key > table_copy[right]) begin
        lo = right + 1;
      end else begin
        lo = left + 1;
        hi = right - 1;
      end
    end
    return res;
  endfunction

  function automatic req_t make_req(input logic act, input int pos,
                                    input logic signed [VALUE_WIDTH-1:0] val,
                                    input int first, input int last);
    req_t item;
    item.action      = act;
    item.position    = IDX_WIDTH'(pos);
    item.item_value  = val;
    item.first_index = IDX_WIDTH'(first);
    item.last_index  = IDX_WIDTH'(last);
    return item;
  endfunction

  function automatic void add_row(input logic act, input int pos,
                                  input logic signed [VALUE_WIDTH-1:0] val,
                                  input int first, input int last,
                                  input bit typed, input logic hit, input int hit_at);
    dir_row_t row;
    row.item               = make_req(act, pos, val, first, last);
    row.typed              = typed;
    row.answer.found       = hit;
    row.answer.found_index = IDX_WIDTH'(hit_at);
    directed_rows.push_back(row);
  endfunction

  // Random transaction. Searches dominate: mostly keys taken from inside the
  // range (hits on a sorted table), some off-by-one neighbors, some noise.
  // Writes mostly keep the table in order; a few drop in a stray value.
  function automatic req_t random_item();
    req_t   item;
    int     pick;
    int     lo;
    int     hi;
    int     at;
    longint floor_v;
    longint ceil_v;
    item.action      = ACT_SEARCH;
    item.position    = IDX_WIDTH'($urandom);
    item.item_value  = $urandom;
    item.first_index = IDX_WIDTH'($urandom);
    item.last_index  = IDX_WIDTH'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      item.action = ACT_WRITE;
      if ($urandom_range(0, 4) != 0) begin
        at      = int'(item.position);
        floor_v = (at > 0) ? longint'(table_copy[at-1]) : longint'(VAL_MIN);
        ceil_v  = (at < TABLE_DEPTH-1) ? longint'(table_copy[at+1]) : longint'(VAL_MAX);
        if (ceil_v < floor_v) ceil_v = floor_v;
        item.item_value = VALUE_WIDTH'(floor_v + longint'($urandom) % (ceil_v - floor_v + 1));
      end
      return item;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = 0;
      hi = TABLE_DEPTH - 1;
    end else if (pick == 1) begin
      lo = $urandom_range(1, TABLE_DEPTH - 1);
      hi = $urandom_range(0, lo - 1);
    end else if (pick == 2) begin
      lo = $urandom_range(0, TABLE_DEPTH - 1);
      hi = lo;
    end else begin
      lo = $urandom_range(0, TABLE_DEPTH - 1);
      hi = $urandom_range(lo, TABLE_DEPTH - 1);
    end
    item.first_index = IDX_WIDTH'(lo);
    item.last_index  = IDX_WIDTH'(hi);
    if (lo <= hi) begin
      pick = $urandom_range(0, 9);
      at   = $urandom_range(lo, hi);
      if (pick < 6) begin
        item.item_value = table_copy[at];
      end else if (pick < 8) begin
        item.item_value = table_copy[at] + ((pick == 6) ? 1 : -1);
      end
    end
    return item;
  endfunction

  // Offer one request transaction and hold it until accepted. A random idle
  // burst may come first. On acceptance, writes go into the table copy and
  // searches queue their answer.
  task automatic send_item(input req_t item, input bit typed, input rsp_t answer);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (item.action == ACT_SEARCH) begin
      pending_answers.push_back(typed ? answer :
                                search_table(item.item_value, int'(item.first_index),
                                             int'(item.last_index)));
    end else begin
      table_copy[item.position] = item.item_value;
    end
  endtask

  // Sender goes quiet until every owed answer has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // Response side: short random stalls, one long stall on request, none at the end.
  initial begin : rsp_sink
    @(posedge clk iff !rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Each accepted response is checked against the oldest owed answer.
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_answers.size() == 0) begin
        $error("response with no search outstanding: found=%0d found_index=%0d",
               rsp.found, rsp.found_index);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.found !== want.found) begin
          $error("found mismatch: expected %0d actual %0d", want.found, rsp.found);
          errors++;
        end
        if (rsp.found_index !== want.found_index) begin
          $error("found_index mismatch: expected %0d actual %0d",
                 want.found_index, rsp.found_index);
          errors++;
        end
      end
    end
  end

  // Watchdog: a run that stops moving on both channels is a hang.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("ternary_search_sorted_table verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    req_t   item;
    longint running;
    int     i;

    // Directed table. Every search here only touches entries written above it.
    // Empty ranges right after reset: nothing read, not found at index 0.
    add_row(ACT_SEARCH, 0, 0, 1023, 0, 1'b1, 1'b0, 0);
    add_row(ACT_SEARCH, 1023, VAL_MAX, 1, 0, 1'b1, 1'b0, 0);
    // Extremes at the table ends; search fields on writes are junk.
    add_row(ACT_WRITE, 0, VAL_MIN, 1023, 1023, 1'b0, 1'b0, 0);
    add_row(ACT_WRITE, 1023, VAL_MAX, 0, 0, 1'b0, 1'b0, 0);
    add_row(ACT_WRITE, 512, 0, 1023, 0, 1'b0, 1'b0, 0);
    add_row(ACT_WRITE, 1, -1, 0, 1023, 1'b0, 1'b0, 0);
    add_row(ACT_WRITE, 2, 100, 0, 0, 1'b0, 1'b0, 0);
    add_row(ACT_WRITE, 3, 200, 0, 0, 1'b0, 1'b0, 0);
    // Single-entry ranges: hit or miss is plain to see.
    add_row(ACT_SEARCH, 1023, VAL_MIN, 0, 0, 1'b1, 1'b1, 0);
    add_row(ACT_SEARCH, 0, VAL_MAX, 1023, 1023, 1'b1, 1'b1, 1023);
    add_row(ACT_SEARCH, 0, 0, 512, 512, 1'b1, 1'b1, 512);
    add_row(ACT_SEARCH, 0, 1, 512, 512, 1'b1, 1'b0, 0);
    add_row(ACT_SEARCH, 0, VAL_MIN, 1023, 1023, 1'b0, 1'b0, 0);
    // Short ranges where the narrowing has to step.
    add_row(ACT_SEARCH, 0, -1, 0, 1, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, VAL_MIN, 0, 1, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, 200, 0, 3, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, 100, 0, 3, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, 150, 0, 3, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, VAL_MAX, 1, 3, 1'b0, 1'b0, 0);
    add_row(ACT_SEARCH, 0, VAL_MIN, 1, 3, 1'b0, 1'b0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].answer);
    end
    drain();

    // Fill the whole table in ascending order, minimum at the bottom and
    // maximum at the top, with the odd repeated value.
    running = longint'(VAL_MIN);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) begin
        running = longint'(VAL_MAX);
      end else if (i > 0 && $urandom_range(0, 15) != 0) begin
        running += $urandom_range(0, 8000000);
        if (running > longint'(VAL_MAX)) running = longint'(VAL_MAX);
      end
      item = make_req(ACT_WRITE, i, VALUE_WIDTH'(running), $urandom_range(0, TABLE_DEPTH - 1),
                      $urandom_range(0, TABLE_DEPTH - 1));
      send_item(item, 1'b0, '0);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_request = 1'b1;
      if (i == 400) drain();
      if (i == RANDOM_ITEMS - 160) quiet = 1'b1;
      send_item(random_item(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d search transactions never answered", pending_answers.size());
      errors++;
    end

    if (errors == 0) begin
      $display("ternary_search_sorted_table verification clean");
    end else begin
      $display("ternary_search_sorted_table verification failed");
    end
    $finish;
  end

endmodule
